// ===== hw/rtl/sm_alu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm_alu_pkg
// Shared types and codes of the sign-magnitude integer ALU.
// ----------------------------------------------------------------------------
package sm_alu_pkg;

    localparam int MAG_BITS = 64;

    // Commands. The last code passes x through unchanged.
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_MOD  = 3'd4;
    localparam logic [2:0] CMD_REM  = 3'd5;
    localparam logic [2:0] CMD_POW  = 3'd6;
    localparam logic [2:0] CMD_PASS = 3'd7;

    // Operand and result kinds. The spare code behaves as based.
    localparam logic [1:0] K_POS   = 2'd0;
    localparam logic [1:0] K_NEG   = 2'd1;
    localparam logic [1:0] K_BASED = 2'd2;
    localparam logic [1:0] K_SPARE = 2'd3;

    // Result status.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_PROMOTE  = 2'd1;
    localparam logic [1:0] STAT_DIVZERO  = 2'd2;
    localparam logic [1:0] STAT_ZEROZERO = 2'd3;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [2:0]          cmd;
        logic [1:0]          x_kind;
        logic [MAG_BITS-1:0] x_mag;
        logic [1:0]          y_kind;
        logic [MAG_BITS-1:0] y_mag;
    } req_t;

endpackage

// ===== hw/rtl/sm_alu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm_alu_front
// Accepts requests, masks magnitudes to the word and folds the spare kind.
// ----------------------------------------------------------------------------
module sm_alu_front #(
    parameter int WORD_BITS = 64
) (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_command,
    input  logic [1:0]                 s_x_kind,
    input  logic [sm_alu_pkg::MAG_BITS-1:0] s_x_mag,
    input  logic [1:0]                 s_y_kind,
    input  logic [sm_alu_pkg::MAG_BITS-1:0] s_y_mag,
    input  logic                       q_full,
    output logic                       q_push,
    output sm_alu_pkg::req_t           q_data
);
    import sm_alu_pkg::*;

    localparam logic [MAG_BITS-1:0] MAG_MASK = {MAG_BITS{1'b1}} >> (MAG_BITS - WORD_BITS);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_data.cmd    = s_command;
        q_data.x_kind = (s_x_kind == K_SPARE) ? K_BASED : s_x_kind;
        q_data.y_kind = (s_y_kind == K_SPARE) ? K_BASED : s_y_kind;
        q_data.x_mag  = s_x_mag & MAG_MASK;
        q_data.y_mag  = s_y_mag & MAG_MASK;
    end

endmodule

// ===== hw/rtl/sm_alu_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm_alu_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module sm_alu_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sm_alu_pkg::req_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output sm_alu_pkg::req_t pop_data
);
    import sm_alu_pkg::*;

    req_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/sm_alu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm_alu_back
// Execution sequencer: add/sub in one step, a shift-add multiplier, a
// restoring divider and square-and-multiply pow, plus the result register.
// ----------------------------------------------------------------------------
module sm_alu_back #(
    parameter int WORD_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_not_empty,
    input  sm_alu_pkg::req_t                q_data,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [1:0]                      m_res_kind,
    output logic [sm_alu_pkg::MAG_BITS-1:0] m_res_mag
);
    import sm_alu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(WORD_BITS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_MULD = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_DIVD = 4'd5;
    localparam logic [3:0] S_POW  = 4'd6;
    localparam logic [3:0] S_SQ   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [1:0] MP_MUL  = 2'd0;
    localparam logic [1:0] MP_POWR = 2'd1;
    localparam logic [1:0] MP_POWB = 2'd2;

    logic [3:0]          state_reg, state_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [1:0]          xk_reg, xk_next;
    logic [1:0]          yk_reg, yk_next;
    logic [W-1:0]        xv_reg, xv_next;
    logic [W-1:0]        yv_reg, yv_next;
    logic [1:0]          st_reg, st_next;
    logic [W-1:0]        hi_reg, hi_next;
    logic [W-1:0]        lo_reg, lo_next;
    logic [W-1:0]        mb_reg, mb_next;
    logic [W-1:0]        b_reg, b_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [1:0]          phase_reg, phase_next;
    logic                big_reg, big_next;
    logic                ovf_reg, ovf_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [1:0]          m_kind_reg, m_kind_next;
    logic [MAG_BITS-1:0] m_mag_reg, m_mag_next;

    logic         xr, yr, xn, yn, same;
    logic [1:0]   sign_kind;
    logic [W:0]   add_sum;
    logic [W-1:0] diff_xy, diff_yx;
    logic [W:0]   mul_sum;
    logic [W:0]   div_trial;
    logic [W:0]   div_diff;
    logic         div_ge;
    logic [W-1:0] e_shift;

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_res_kind = m_kind_reg;
    assign m_res_mag  = m_mag_reg;

    always_comb begin
        xr        = (xk_reg != K_BASED);
        yr        = (yk_reg != K_BASED);
        xn        = (xk_reg == K_NEG);
        yn        = (yk_reg == K_NEG);
        same      = (cmd_reg == CMD_ADD) ? (xn == yn) : (xn != yn);
        sign_kind = (xn == yn) ? K_POS : K_NEG;
        add_sum   = {1'b0, xv_reg} + {1'b0, yv_reg};
        diff_xy   = xv_reg - yv_reg;
        diff_yx   = yv_reg - xv_reg;
        mul_sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mb_reg} : {(W+1){1'b0}});
        div_trial = {hi_reg, lo_reg[W-1]};
        div_diff  = div_trial - {1'b0, yv_reg};
        div_ge    = (div_trial >= {1'b0, yv_reg});
        e_shift   = yv_reg >> 1;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        xk_next       = xk_reg;
        yk_next       = yk_reg;
        xv_next       = xv_reg;
        yv_next       = yv_reg;
        st_next       = st_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        mb_next       = mb_reg;
        b_next        = b_reg;
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        big_next      = big_reg;
        ovf_next      = ovf_reg;
        m_status_next = m_status_reg;
        m_kind_next   = m_kind_reg;
        m_mag_next    = m_mag_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        q_pop         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data.cmd;
                    xk_next    = q_data.x_kind;
                    yk_next    = q_data.y_kind;
                    xv_next    = q_data.x_mag[W-1:0];
                    yv_next    = q_data.y_mag[W-1:0];
                    st_next    = STAT_OK;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
                case (cmd_reg)
                    CMD_ADD, CMD_SUB: begin
                        if (same) begin
                            if (add_sum[W] && xr && yr) begin
                                st_next = STAT_PROMOTE;
                            end else begin
                                xv_next = add_sum[W-1:0];
                            end
                        end else if (!xr) begin
                            xv_next = diff_xy;
                        end else if (yv_reg >= xv_reg) begin
                            xv_next = diff_yx;
                            xk_next = (diff_yx == '0 || xn) ? K_POS : K_NEG;
                        end else begin
                            xv_next = diff_xy;
                        end
                    end
                    CMD_MUL: begin
                        hi_next    = '0;
                        lo_next    = xv_reg;
                        mb_next    = yv_reg;
                        cnt_next   = CW'(W - 1);
                        phase_next = MP_MUL;
                        state_next = S_MUL;
                    end
                    CMD_DIV, CMD_MOD, CMD_REM: begin
                        if (yv_reg == '0) begin
                            st_next = STAT_DIVZERO;
                        end else begin
                            hi_next    = '0;
                            lo_next    = xv_reg;
                            cnt_next   = CW'(W - 1);
                            state_next = S_DIV;
                        end
                    end
                    CMD_POW: begin
                        if (xv_reg == '0 && yv_reg == '0) begin
                            st_next = STAT_ZEROZERO;
                        end else if (yn) begin
                            st_next = STAT_PROMOTE;
                        end else begin
                            if (xn) begin
                                xk_next = yv_reg[0] ? K_NEG : K_POS;
                            end
                            b_next     = xv_reg;
                            xv_next    = W'(1);
                            big_next   = 1'b0;
                            ovf_next   = 1'b0;
                            state_next = S_POW;
                        end
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_MUL: begin
                hi_next  = mul_sum[W:1];
                lo_next  = {mul_sum[0], lo_reg[W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_MULD;
                end
            end
            S_MULD: begin
                case (phase_reg)
                    MP_MUL: begin
                        state_next = S_FIN;
                        if (!xr || !yr) begin
                            xv_next = lo_reg;
                        end else if (hi_reg != '0) begin
                            st_next = STAT_PROMOTE;
                        end else begin
                            xv_next = lo_reg;
                            xk_next = sign_kind;
                        end
                    end
                    MP_POWR: begin
                        xv_next    = lo_reg;
                        ovf_next   = ovf_reg || big_reg || (hi_reg != '0);
                        state_next = S_SQ;
                    end
                    default: begin
                        b_next     = lo_reg;
                        big_next   = big_reg || (hi_reg != '0);
                        state_next = S_POW;
                    end
                endcase
            end
            S_DIV: begin
                hi_next  = div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
                lo_next  = {lo_reg[W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DIVD;
                end
            end
            S_DIVD: begin
                // Quotient sits in lo, remainder in hi.
                state_next = S_FIN;
                case (cmd_reg)
                    CMD_DIV: begin
                        if (!xr || !yr) begin
                            xv_next = lo_reg;
                        end else if (hi_reg != '0) begin
                            st_next = STAT_PROMOTE;
                        end else begin
                            xv_next = lo_reg;
                            xk_next = sign_kind;
                        end
                    end
                    CMD_MOD: begin
                        if (!xr || !yr) begin
                            xv_next = hi_reg;
                        end else begin
                            xv_next = (hi_reg != '0 && xn != yn) ? (yv_reg - hi_reg) : hi_reg;
                            xk_next = yn ? K_NEG : K_POS;
                        end
                    end
                    default: begin
                        xv_next = hi_reg;
                    end
                endcase
            end
            S_POW: begin
                if (yv_reg == '0) begin
                    if (ovf_reg && xr && yr) begin
                        st_next = STAT_PROMOTE;
                    end
                    state_next = S_FIN;
                end else if (yv_reg[0]) begin
                    hi_next    = '0;
                    lo_next    = xv_reg;
                    mb_next    = b_reg;
                    cnt_next   = CW'(W - 1);
                    phase_next = MP_POWR;
                    state_next = S_MUL;
                end else begin
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                yv_next = e_shift;
                if (e_shift != '0) begin
                    hi_next    = '0;
                    lo_next    = b_reg;
                    mb_next    = b_reg;
                    cnt_next   = CW'(W - 1);
                    phase_next = MP_POWB;
                    state_next = S_MUL;
                end else begin
                    state_next = S_POW;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (st_reg != STAT_OK) begin
                        m_status_next = st_reg;
                        m_kind_next   = K_POS;
                        m_mag_next    = '0;
                    end else begin
                        m_status_next = STAT_OK;
                        m_kind_next   = (xk_reg == K_NEG && xv_reg == '0) ? K_POS : xk_reg;
                        m_mag_next    = MAG_BITS'(xv_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        xk_reg       <= xk_next;
        yk_reg       <= yk_next;
        xv_reg       <= xv_next;
        yv_reg       <= yv_next;
        st_reg       <= st_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        mb_reg       <= mb_next;
        b_reg        <= b_next;
        cnt_reg      <= cnt_next;
        phase_reg    <= phase_next;
        big_reg      <= big_next;
        ovf_reg      <= ovf_next;
        m_status_reg <= m_status_next;
        m_kind_reg   <= m_kind_next;
        m_mag_reg    <= m_mag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/sign_magnitude_int_alu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_magnitude_int_alu_core
// Sign-magnitude integer ALU: add, sub, mul, div, mod, rem and pow on
// operands that are positive, negative or based (wrapping) words.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   s_        in          s_valid / s_ready    command, x_kind, x_mag, y_kind, y_mag
//   m_        out         m_valid / m_ready    status, res_kind, res_mag
//
// Add and sub go from the execute state straight to the result register;
// mul runs through the one-bit-per-cycle shift-add multiplier, and div,
// mod and rem through the restoring divider. Pow runs up to
// 2 * WORD_BITS - 1 multiplier passes, one per exponent bit set and one
// per squaring.
// Reset is synchronous and active low; it empties the request queue and
// drops any pending result. A stalled result port holds the finished result
// while the front keeps accepting up to two more requests into the queue.
// ----------------------------------------------------------------------------
module sign_magnitude_int_alu_core #(
    parameter int WORD_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_command,
    input  logic [1:0]                      s_x_kind,
    input  logic [sm_alu_pkg::MAG_BITS-1:0] s_x_mag,
    input  logic [1:0]                      s_y_kind,
    input  logic [sm_alu_pkg::MAG_BITS-1:0] s_y_mag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [1:0]                      m_res_kind,
    output logic [sm_alu_pkg::MAG_BITS-1:0] m_res_mag
);
    import sm_alu_pkg::*;

    // Front side: classified requests headed for the queue.
    logic q_full;
    logic q_push;
    req_t q_in;

    // Back side: the oldest queued request.
    logic q_not_empty;
    logic q_pop;
    req_t q_out;

    // The front masks magnitudes to the word and folds the spare kind code
    // into based, so the back only ever sees three kinds.
    sm_alu_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_x_kind  (s_x_kind),
        .s_x_mag   (s_x_mag),
        .s_y_kind  (s_y_kind),
        .s_y_mag   (s_y_mag),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // The queue lets the front keep taking requests while the back grinds
    // through a long multiply, divide or pow.
    sm_alu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    // The back runs one request at a time and owns the result register.
    sm_alu_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_res_kind  (m_res_kind),
        .m_res_mag   (m_res_mag)
    );

endmodule

// ===== hw/rtl/sm_alu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm_alu_chk
// Port-level checks on the ALU's result channel.
// ----------------------------------------------------------------------------
module sm_alu_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [1:0]                      m_status,
    input logic [1:0]                      m_res_kind,
    input logic [sm_alu_pkg::MAG_BITS-1:0] m_res_mag
);
    import sm_alu_pkg::*;

    // A stalled result stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_res_kind)
            && $stable(m_res_mag))
        else $error("result changed while stalled");

    // A failed request carries an empty result.
    a_fail_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_res_kind == K_POS && m_res_mag == '0)
        else $error("failed request carries a value");

    // Negative zero is never given out.
    a_no_neg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res_kind == K_NEG |-> m_res_mag != '0)
        else $error("negative zero result");

    // The spare kind code never leaves the block.
    a_kind_folded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_res_kind != K_SPARE)
        else $error("spare kind on result");

endmodule

bind sign_magnitude_int_alu_core sm_alu_chk u_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_res_kind (m_res_kind),
    .m_res_mag  (m_res_mag)
);

// ===== dv/sign_magnitude_int_alu_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_magnitude_int_alu_core_test
// Self-checking bench for the sign-magnitude integer ALU. A directed set of
// corner requests is followed by random requests. The bench predicts each
// result in place and compares the results in order, while both ports idle
// and stall at random.
// ----------------------------------------------------------------------------
import sm_alu_pkg::*;

typedef struct {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [63:0] mag;
} alu_answer_t;

// Predicts ALU answers and keeps the answers still owed by the block.
class alu_scoreboard;
    alu_answer_t owed[$];
    int          errors;
    int          cmd_seen[8];
    int          status_seen[4];

    static function automatic logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
        return {64'd0, a} * {64'd0, b};
    endfunction

    static function automatic alu_answer_t compute(logic [2:0] cmd, logic [1:0] xk_in,
                                                   logic [63:0] xv, logic [1:0] yk_in,
                                                   logic [63:0] yv);
        alu_answer_t ans;
        logic [1:0]  xk, yk;
        logic        xr, yr, xn, yn, like, big, ovf;
        logic [64:0] sum;
        logic [127:0] p;
        logic [63:0] r, b, e, rm;
        xk = (xk_in == K_SPARE) ? K_BASED : xk_in;
        yk = (yk_in == K_SPARE) ? K_BASED : yk_in;
        xr = xk != K_BASED;
        yr = yk != K_BASED;
        xn = xk == K_NEG;
        yn = yk == K_NEG;
        ans.status = STAT_OK;
        case (cmd)
            CMD_ADD, CMD_SUB: begin
                like = (cmd == CMD_ADD) ? (xn == yn) : (xn != yn);
                if (like) begin
                    sum = {1'b0, xv} + {1'b0, yv};
                    if (sum[64] && xr && yr) ans.status = STAT_PROMOTE;
                    else xv = sum[63:0];
                end else if (!xr) begin
                    xv = xv - yv;
                end else if (yv >= xv) begin
                    xv = yv - xv;
                    xk = (xv == 0 || xk == K_NEG) ? K_POS : K_NEG;
                end else begin
                    xv = xv - yv;
                end
            end
            CMD_MUL: begin
                p = wide_mul(xv, yv);
                if (!xr || !yr) xv = p[63:0];
                else if (p[127:64] != 0) ans.status = STAT_PROMOTE;
                else begin
                    xv = p[63:0];
                    xk = (xn == yn) ? K_POS : K_NEG;
                end
            end
            CMD_DIV: begin
                if (yv == 0) ans.status = STAT_DIVZERO;
                else if (!xr || !yr) xv = xv / yv;
                else if (xv % yv != 0) ans.status = STAT_PROMOTE;
                else begin
                    xv = xv / yv;
                    xk = (xn == yn) ? K_POS : K_NEG;
                end
            end
            CMD_MOD: begin
                if (yv == 0) ans.status = STAT_DIVZERO;
                else if (!xr || !yr) xv = xv % yv;
                else begin
                    rm = xv % yv;
                    if (rm != 0 && xn != yn) rm = yv - rm;
                    xv = rm;
                    xk = yn ? K_NEG : K_POS;
                end
            end
            CMD_REM: begin
                if (yv == 0) ans.status = STAT_DIVZERO;
                else xv = xv % yv;
            end
            CMD_POW: begin
                if (xv == 0 && yv == 0) ans.status = STAT_ZEROZERO;
                else if (yn) ans.status = STAT_PROMOTE;
                else begin
                    big = 0;
                    ovf = 0;
                    r = 64'd1;
                    b = xv;
                    e = yv;
                    if (xn) xk = yv[0] ? K_NEG : K_POS;
                    while (e != 0) begin
                        if (e[0]) begin
                            if (big) ovf = 1;
                            p = wide_mul(r, b);
                            if (p[127:64] != 0) ovf = 1;
                            r = p[63:0];
                        end
                        e = e >> 1;
                        if (e != 0) begin
                            p = wide_mul(b, b);
                            if (p[127:64] != 0) big = 1;
                            b = p[63:0];
                        end
                    end
                    if (ovf && xr && yr) ans.status = STAT_PROMOTE;
                    else xv = r;
                end
            end
            default: ;
        endcase
        if (ans.status != STAT_OK) begin
            xk = K_POS;
            xv = 0;
        end else if (xk == K_NEG && xv == 0) begin
            xk = K_POS;
        end
        ans.kind = xk;
        ans.mag = xv;
        return ans;
    endfunction

    function void note_request(logic [2:0] cmd, logic [1:0] xk, logic [63:0] xv,
                               logic [1:0] yk, logic [63:0] yv);
        alu_answer_t ans;
        ans = compute(cmd, xk, xv, yk, yv);
        owed.push_back(ans);
        cmd_seen[cmd]++;
        status_seen[ans.status]++;
    endfunction

    function void check_result(logic [1:0] st, logic [1:0] kind, logic [63:0] mag);
        alu_answer_t want;
        if (owed.size() == 0) begin
            $error("result with no request outstanding: status %0d kind %0d mag %h",
                   st, kind, mag);
            errors++;
            return;
        end
        want = owed.pop_front();
        if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            errors++;
        end
        if (kind !== want.kind) begin
            $error("res_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
        end
        if (mag !== want.mag) begin
            $error("res_mag: expected %h, actual %h", want.mag, mag);
            errors++;
        end
    endfunction
endclass

module sign_magnitude_int_alu_core_test;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [1:0]  s_x_kind;
    logic [63:0] s_x_mag;
    logic [1:0]  s_y_kind;
    logic [63:0] s_y_mag;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [1:0]  m_res_kind;
    logic [63:0] m_res_mag;

    alu_scoreboard board;
    // While calm is set neither side idles at random.
    logic        calm;
    int          results_seen;

    sign_magnitude_int_alu_core #(.WORD_BITS(64)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_x_kind(s_x_kind), .s_x_mag(s_x_mag), .s_y_kind(s_y_kind), .s_y_mag(s_y_mag),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_res_kind(m_res_kind), .m_res_mag(m_res_mag)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offers one request, holds it until it is taken and then records it.
    task automatic send_request(logic [2:0] cmd, logic [1:0] xk, logic [63:0] xv,
                                logic [1:0] yk, logic [63:0] yv);
        int gap;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_x_kind  <= xk;
        s_x_mag   <= xv;
        s_y_kind  <= yk;
        s_y_mag   <= yv;
        do @(posedge aclk); while (!s_ready);
        board.note_request(cmd, xk, xv, yk, yv);
        // Valid stays up when the next request follows right away.
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Magnitudes drawn from the interesting corners as well as from anywhere.
    function automatic logic [63:0] pick_mag();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return {64{1'b1}} - 64'($urandom_range(0, 3));
            3: return 64'd1 << $urandom_range(0, 63);
            4, 5: return 64'($urandom_range(0, 1000));
            6: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8) return K_POS;
        if (r < 15) return K_NEG;
        if (r < 19) return K_BASED;
        return K_SPARE;
    endfunction

    task automatic send_random();
        logic [2:0]  cmd;
        logic [1:0]  xk, yk;
        logic [63:0] xv, yv;
        cmd = (($urandom_range(0, 49)) == 0) ? CMD_PASS : 3'($urandom_range(0, 6));
        xk = pick_kind();
        yk = pick_kind();
        xv = pick_mag();
        yv = pick_mag();
        if ((cmd == CMD_DIV || cmd == CMD_MOD) && $urandom_range(0, 2) == 0) begin
            // Make an exact multiple so that exact quotients and zero remainders occur.
            yv = 64'($urandom_range(1, 100000));
            xv = yv * 64'($urandom_range(0, 100000));
        end
        if (cmd == CMD_POW) begin
            // Long exponents are slow in the block, so only a few are used.
            if ($urandom_range(0, 39) == 0) yv = {$urandom(), $urandom()};
            else yv = 64'($urandom_range(0, 70));
            if ($urandom_range(0, 1) == 0) xv = 64'($urandom_range(0, 20));
        end
        send_request(cmd, xk, xv, yk, yv);
    endtask

    // Result side: random stalls, and one long hold-off once the run is
    // under way so that the block backs up into its request queue.
    initial begin
        int  stall;
        bit  held;
        stall = 0;
        held = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_valid && m_ready) begin
                board.check_result(m_status, m_res_kind, m_res_mag);
                results_seen++;
            end
            if (!held && results_seen == 150) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_ready <= (stall == 0);
                if (stall > 0) stall--;
            end
            @(posedge aclk);
        end
    end

    initial begin
        int waited;
        board = new();
        calm = 1'b0;
        results_seen = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_command = CMD_ADD;
        s_x_kind  = K_POS;
        s_x_mag   = '0;
        s_y_kind  = K_POS;
        s_y_mag   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: real overflow, based wrap, sign flips, negative
        // zero, inexact and by-zero division, floored mod, pow corners,
        // the spare kind and the unused command.
        send_request(CMD_ADD, K_POS, {64{1'b1}}, K_POS, 64'd1);
        send_request(CMD_ADD, K_BASED, {64{1'b1}}, K_POS, 64'd2);
        send_request(CMD_ADD, K_NEG, 64'd5, K_POS, 64'd9);
        send_request(CMD_SUB, K_NEG, 64'd7, K_NEG, 64'd7);
        send_request(CMD_SUB, K_POS, 64'd3, K_POS, 64'd10);
        send_request(CMD_SUB, K_SPARE, 64'd0, K_NEG, 64'd1);
        send_request(CMD_MUL, K_NEG, 64'h1_0000_0000, K_POS, 64'h1_0000_0000);
        send_request(CMD_MUL, K_NEG, {64{1'b1}}, K_NEG, 64'd1);
        send_request(CMD_MUL, K_NEG, 64'd0, K_POS, 64'd12);
        send_request(CMD_MUL, K_BASED, {64{1'b1}}, K_SPARE, {64{1'b1}});
        send_request(CMD_DIV, K_POS, 64'd7, K_NEG, 64'd2);
        send_request(CMD_DIV, K_NEG, 64'd8, K_POS, 64'd2);
        send_request(CMD_DIV, K_POS, 64'd8, K_POS, 64'd0);
        send_request(CMD_DIV, K_BASED, {64{1'b1}}, K_POS, 64'd3);
        send_request(CMD_MOD, K_NEG, 64'd7, K_POS, 64'd3);
        send_request(CMD_MOD, K_POS, 64'd7, K_NEG, 64'd3);
        send_request(CMD_MOD, K_BASED, 64'd7, K_NEG, 64'd3);
        send_request(CMD_REM, K_NEG, 64'd7, K_POS, 64'd0);
        send_request(CMD_REM, K_NEG, {64{1'b1}}, K_POS, 64'd10);
        send_request(CMD_POW, K_NEG, 64'd0, K_POS, 64'd0);
        send_request(CMD_POW, K_POS, 64'd2, K_NEG, 64'd3);
        send_request(CMD_POW, K_NEG, 64'd3, K_POS, 64'd3);
        send_request(CMD_POW, K_POS, 64'd2, K_POS, 64'd64);
        send_request(CMD_POW, K_BASED, 64'd3, K_POS, {64{1'b1}});
        send_request(CMD_PASS, K_SPARE, {64{1'b1}}, K_NEG, 64'd1);

        for (int i = 0; i < 1000; i++) begin
            if (i % 250 == 0) calm = ($urandom_range(0, 2) == 0);
            send_random();
        end
        s_valid <= 1'b0;

        waited = 0;
        while (board.owed.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (300) @(posedge aclk);
        $display("Checked %0d results: add %0d sub %0d mul %0d div %0d mod %0d rem %0d pow %0d.",
                 results_seen, board.cmd_seen[0], board.cmd_seen[1], board.cmd_seen[2],
                 board.cmd_seen[3], board.cmd_seen[4], board.cmd_seen[5], board.cmd_seen[6]);
        $display("Status mix: ok %0d, promote %0d, divide by zero %0d, zero to zero %0d.",
                 board.status_seen[0], board.status_seen[1], board.status_seen[2],
                 board.status_seen[3]);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(400_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
